// ===== rtl/xrbs_pkg.sv =====
// Shared types and constants of the xoshiro256** random byte source.
package xrbs_pkg;

  // splitmix64 constants
  localparam logic [63:0] SM_GAMMA = 64'h9E37_79B9_7F4A_7C15;
  localparam logic [63:0] SM_MUL1  = 64'hBF58_476D_1CE4_E5B9;
  localparam logic [63:0] SM_MUL2  = 64'h94D0_49BB_1331_11EB;

  // Datapath operation codes
  typedef logic [3:0] xrbs_op_t;
  localparam xrbs_op_t OP_NONE  = 4'd0;  // hold
  localparam xrbs_op_t OP_LOAD  = 4'd1;  // take request length, load walker from seed
  localparam xrbs_op_t OP_ADD   = 4'd2;  // advance walker by gamma
  localparam xrbs_op_t OP_XS30  = 4'd3;  // z ^= z >> 30
  localparam xrbs_op_t OP_XS27  = 4'd4;  // z ^= z >> 27
  localparam xrbs_op_t OP_MLO   = 4'd5;  // low x low partial product
  localparam xrbs_op_t OP_MX1   = 4'd6;  // high x low cross term
  localparam xrbs_op_t OP_MX2   = 4'd7;  // low x high cross term, product into z
  localparam xrbs_op_t OP_STORE = 4'd8;  // z ^= z >> 31 into a generator word
  localparam xrbs_op_t OP_EMIT  = 4'd9;  // output one word, advance generator

  // Sequencer step that closes one splitmix64 round
  localparam logic [3:0] SEED_LAST_STEP = 4'd9;

  typedef struct packed {
    xrbs_op_t    op;
    logic        csel;   // 0: SM_MUL1, 1: SM_MUL2
    logic [1:0]  widx;   // generator word to store
  } xrbs_cmd_t;

  typedef struct packed {
    logic len_zero;   // request length on the input is zero
    logic rem_last;   // current word is the last of the request
    logic out_free;   // output register can take a word this cycle
  } xrbs_sts_t;

endpackage

// ===== rtl/xoshiro_random_byte_source.sv =====
// The first word is registered in the output register at the first emit after the request transfer,
// after seeding if needed; seeding runs four splitmix64 rounds on one shared 32x32 multiplier.
// Throughput: one 64-bit word per cycle while out_ready holds, ceil(len/8) words per request
// with len capped at MAX_REQUEST_BYTES; the emit stage is the output register.
// Reset (rst_n, synchronous, active low) clears control state and the seeded flag and
// loads a zero seed, so the first request expands seed zero unless a seed was written.
module xoshiro_random_byte_source #(
  parameter int MAX_REQUEST_BYTES = 512
) (
  input  logic        clk,
  input  logic        rst_n,
  // request channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [9:0]  in_byte_length,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_random_word,
  output logic [3:0]  out_valid_bytes,
  output logic        out_last_word,
  // seed register write
  input  logic        cfg_we,
  input  logic [63:0] cfg_wdata
);
  import xrbs_pkg::*;

  // Command and status between sequencer and datapath
  xrbs_cmd_t cmd;
  xrbs_sts_t sts;

  // Sequencer: accept a request in idle, expand the seed if needed, then
  // emit one word per free output slot until the last word is emitted.
  xrbs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cfg_we   (cfg_we),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Datapath: hold the seed, walk splitmix64, advance xoshiro256**,
  // and hold each finished word in the output register until transfer.
  xrbs_datapath #(
    .MAX_REQUEST_BYTES (MAX_REQUEST_BYTES)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_byte_length  (in_byte_length),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_random_word (out_random_word),
    .out_valid_bytes (out_valid_bytes),
    .out_last_word   (out_last_word)
  );

endmodule

// ===== rtl/xrbs_datapath.sv =====
// Datapath: seed, splitmix64 walker, shared 32x32 multiplier, generator state, output register.
module xrbs_datapath #(
  parameter int MAX_REQUEST_BYTES = 512
) (
  input  logic                clk,
  input  logic                rst_n,
  input  xrbs_pkg::xrbs_cmd_t cmd,
  output xrbs_pkg::xrbs_sts_t sts,
  input  logic [9:0]          in_byte_length,
  input  logic                cfg_we,
  input  logic [63:0]         cfg_wdata,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [63:0]         out_random_word,
  output logic [3:0]          out_valid_bytes,
  output logic                out_last_word
);
  import xrbs_pkg::*;

  localparam int RW = $clog2(MAX_REQUEST_BYTES + 1);
  localparam int CW = (RW > 10) ? RW : 10;
  localparam logic [CW-1:0] MAX_LEN = CW'(MAX_REQUEST_BYTES);

  logic [63:0]   seed_r;
  logic [63:0]   walker_r;
  logic [63:0]   z_r;
  logic [63:0]   acc_r;
  logic [63:0]   gen_r [4];
  logic [63:0]   s1x5_r;
  logic [RW-1:0] rem_r;
  logic          out_valid_r;
  logic [63:0]   out_word_r;
  logic [3:0]    out_bytes_r;
  logic          out_last_r;

  logic [CW-1:0] len_ext;
  logic [RW-1:0] len_sat;
  logic [63:0]   walker_nxt;
  logic [63:0]   mul_c;
  logic [31:0]   mul_a;
  logic [31:0]   mul_b;
  logic [63:0]   prod;
  logic [63:0]   z_fin;
  logic [63:0]   rot7;
  logic [63:0]   word_nxt;
  logic [3:0]    take;
  logic [63:0]   t17;
  logic [63:0]   s0_nxt;
  logic [63:0]   s1_nxt;
  logic [63:0]   s2_nxt;
  logic [63:0]   s3_x;
  logic [63:0]   s3_nxt;

  // Saturate the request length
  assign len_ext = CW'(in_byte_length);
  assign len_sat = (len_ext > MAX_LEN) ? RW'(MAX_LEN) : RW'(len_ext);

  assign walker_nxt = walker_r + SM_GAMMA;

  // Shared multiplier: one 32x32 product per cycle
  assign mul_c = cmd.csel ? SM_MUL2 : SM_MUL1;
  assign mul_a = (cmd.op == OP_MX1) ? z_r[63:32] : z_r[31:0];
  assign mul_b = (cmd.op == OP_MX2) ? mul_c[63:32] : mul_c[31:0];
  assign prod  = 64'(mul_a) * 64'(mul_b);

  assign z_fin = z_r ^ (z_r >> 31);

  // Output word: rotl(s1 * 5, 7) * 9
  assign rot7     = {s1x5_r[56:0], s1x5_r[63:57]};
  assign word_nxt = rot7 + (rot7 << 3);
  assign take     = (rem_r >= RW'(8)) ? 4'd8 : rem_r[3:0];

  // Generator advance
  assign t17    = gen_r[1] << 17;
  assign s2_nxt = gen_r[2] ^ gen_r[0] ^ t17;
  assign s1_nxt = gen_r[1] ^ gen_r[2] ^ gen_r[0];
  assign s0_nxt = gen_r[0] ^ gen_r[3] ^ gen_r[1];
  assign s3_x   = gen_r[3] ^ gen_r[1];
  assign s3_nxt = {s3_x[18:0], s3_x[63:19]};

  // Seed register: zero after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= '0;
    end else if (cfg_we) begin
      seed_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_LOAD: begin
        rem_r    <= len_sat;
        walker_r <= seed_r;
      end
      OP_ADD: begin
        walker_r <= walker_nxt;
        z_r      <= walker_nxt;
      end
      OP_XS30: z_r <= z_r ^ (z_r >> 30);
      OP_XS27: z_r <= z_r ^ (z_r >> 27);
      OP_MLO:  acc_r <= prod;
      OP_MX1:  acc_r[63:32] <= acc_r[63:32] + prod[31:0];
      OP_MX2:  z_r <= {acc_r[63:32] + prod[31:0], acc_r[31:0]};
      OP_STORE: begin
        gen_r[cmd.widx] <= z_fin;
        if (cmd.widx == 2'd1) begin
          s1x5_r <= z_fin + (z_fin << 2);
        end
      end
      OP_EMIT: begin
        out_word_r  <= word_nxt;
        out_bytes_r <= take;
        out_last_r  <= (rem_r <= RW'(8));
        rem_r       <= rem_r - RW'(take);
        gen_r[0]    <= s0_nxt;
        gen_r[1]    <= s1_nxt;
        gen_r[2]    <= s2_nxt;
        gen_r[3]    <= s3_nxt;
        s1x5_r      <= s1_nxt + (s1_nxt << 2);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.op == OP_EMIT) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign sts.len_zero = (in_byte_length == 10'd0);
  assign sts.rem_last = (rem_r <= RW'(8));
  assign sts.out_free = !out_valid_r || out_ready;

  assign out_valid       = out_valid_r;
  assign out_random_word = out_word_r;
  assign out_valid_bytes = out_bytes_r;
  assign out_last_word   = out_last_r;

endmodule

// ===== rtl/xrbs_ctrl.sv =====
// Controller: request acceptance, splitmix64 seeding sequence and word emission.
module xrbs_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                cfg_we,
  input  xrbs_pkg::xrbs_sts_t sts,
  output xrbs_pkg::xrbs_cmd_t cmd
);
  import xrbs_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SEED = 2'd1;
  localparam logic [1:0] ST_GEN  = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic [3:0] step_r, step_nxt;
  logic [1:0] widx_r, widx_nxt;
  logic       seeded_r, seeded_nxt;

  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt  = state_r;
    step_nxt   = step_r;
    widx_nxt   = widx_r;
    seeded_nxt = seeded_r;
    cmd.op     = OP_NONE;
    cmd.csel   = 1'b0;
    cmd.widx   = widx_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid && !sts.len_zero) begin
          cmd.op    = OP_LOAD;
          step_nxt  = 4'd0;
          widx_nxt  = 2'd0;
          state_nxt = seeded_r ? ST_GEN : ST_SEED;
        end
      end
      ST_SEED: begin
        unique case (step_r)
          4'd0: cmd.op = OP_ADD;
          4'd1: cmd.op = OP_XS30;
          4'd2: cmd.op = OP_MLO;
          4'd3: cmd.op = OP_MX1;
          4'd4: cmd.op = OP_MX2;
          4'd5: cmd.op = OP_XS27;
          4'd6: begin cmd.op = OP_MLO; cmd.csel = 1'b1; end
          4'd7: begin cmd.op = OP_MX1; cmd.csel = 1'b1; end
          4'd8: begin cmd.op = OP_MX2; cmd.csel = 1'b1; end
          4'd9: cmd.op = OP_STORE;
          default: cmd.op = OP_NONE;
        endcase
        if (step_r == SEED_LAST_STEP) begin
          step_nxt = 4'd0;
          widx_nxt = widx_r + 2'd1;
          if (widx_r == 2'd3) begin
            seeded_nxt = 1'b1;
            state_nxt  = ST_GEN;
          end
        end else begin
          step_nxt = step_r + 4'd1;
        end
      end
      ST_GEN: begin
        if (sts.out_free) begin
          cmd.op = OP_EMIT;
          if (sts.rem_last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    // A seed write forces a fresh expansion
    if (cfg_we) begin
      seeded_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      step_r   <= 4'd0;
      widx_r   <= 2'd0;
      seeded_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      step_r   <= step_nxt;
      widx_r   <= widx_nxt;
      seeded_r <= seeded_nxt;
    end
  end

endmodule

// ===== verif/xrbs_word_checker.sv =====
// Scoreboard for the random byte source: predicts each word of a request and checks the result channel.
module xrbs_word_checker #(
  parameter int MAX_REQUEST_BYTES = 512
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [9:0]  in_byte_length,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [63:0] out_random_word,
  input  logic [3:0]  out_valid_bytes,
  input  logic        out_last_word,
  input  logic        cfg_we,
  input  logic [63:0] cfg_wdata,
  input  logic        check_drained,
  output int          fail_count,
  output int          words_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [63:0] GOLDEN_GAMMA = 64'h9E37_79B9_7F4A_7C15;
  localparam logic [63:0] MIX_MUL_A    = 64'hBF58_476D_1CE4_E5B9;
  localparam logic [63:0] MIX_MUL_B    = 64'h94D0_49BB_1331_11EB;

  typedef struct packed {
    logic [63:0] word;
    logic [3:0]  nbytes;
    logic        last;
  } rand_word_t;

  logic [63:0] seed_reg;
  logic [63:0] gen_state [4];
  logic        seeded;
  logic [63:0] walker;
  rand_word_t  expected_words [$];
  int          words_seen;

  initial begin
    fail_count    = 0;
    words_pending = 0;
    words_seen    = 0;
  end

  task automatic report_mismatch(input string what);
    $display("%0t checker: word %0d: %s", $realtime, words_seen, what);
    fail_count++;
  endtask

  function automatic logic [63:0] rotl(input logic [63:0] x, input int k);
    return (x << k) | (x >> (64 - k));
  endfunction

  // expand the seed into the four generator words by splitmix64
  task automatic load_generator();
    logic [63:0] z;
    walker = seed_reg;
    for (int i = 0; i < 4; i++) begin
      walker = walker + GOLDEN_GAMMA;
      z = walker;
      z = (z ^ (z >> 30)) * MIX_MUL_A;
      z = (z ^ (z >> 27)) * MIX_MUL_B;
      gen_state[i] = z ^ (z >> 31);
    end
    seeded = 1'b1;
  endtask

  task automatic advance_generator(output logic [63:0] word);
    logic [63:0] t;
    word = rotl(gen_state[1] * 64'd5, 7) * 64'd9;
    t = gen_state[1] << 17;
    gen_state[2] ^= gen_state[0];
    gen_state[3] ^= gen_state[1];
    gen_state[1] ^= gen_state[2];
    gen_state[0] ^= gen_state[3];
    gen_state[2] ^= t;
    gen_state[3] = rotl(gen_state[3], 45);
  endtask

  task automatic predict_request(input logic [9:0] length);
    int remaining;
    int take;
    rand_word_t w;
    remaining = (length > MAX_REQUEST_BYTES) ? MAX_REQUEST_BYTES : int'(length);
    if (remaining == 0) return;  // empty request: no word, no seeding
    if (!seeded) load_generator();
    while (remaining > 0) begin
      take = (remaining >= 8) ? 8 : remaining;
      remaining -= take;
      advance_generator(w.word);
      w.nbytes = 4'(take);
      w.last   = (remaining == 0);
      expected_words.push_back(w);
    end
  endtask

  always @(posedge clk) begin : watch
    rand_word_t want;
    if (!rst_n) begin
      seed_reg  = '0;
      gen_state = '{default: '0};
      seeded    = 1'b0;
      walker    = '0;
      expected_words.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_words.size() == 0) begin
          report_mismatch($sformatf("unexpected word %h", out_random_word));
        end else begin
          want = expected_words.pop_front();
          if (out_random_word !== want.word)
            report_mismatch($sformatf("random_word %h, want %h", out_random_word, want.word));
          if (out_valid_bytes !== want.nbytes)
            report_mismatch($sformatf("valid_bytes %0d, want %0d", out_valid_bytes,
                                      want.nbytes));
          if (out_last_word !== want.last)
            report_mismatch($sformatf("last_word %b, want %b", out_last_word, want.last));
        end
        words_seen++;
      end
      if (cfg_we) begin
        seed_reg = cfg_wdata;
        seeded   = 1'b0;
      end
      if (in_valid && in_ready) predict_request(in_byte_length);
      if (check_drained && expected_words.size() != 0)
        report_mismatch($sformatf("%0d words never arrived", expected_words.size()));
    end
    words_pending <= expected_words.size();
  end

endmodule

// ===== verif/tb_top.sv =====
// Top-level testbench of the xoshiro256** random byte source: stimulus, flow control and verdict.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_BYTES        = 512;
  // Cycles to let pass once no word is outstanding: covers a seeding pass
  // plus the request pipeline, so an empty request can finish before a seed write.
  localparam int SETTLE_CYCLES    = 60;
  localparam int LONG_HOLD_CYCLES = 300;

  logic        clk            = 1'b0;
  logic        rst_n          = 1'b0;
  logic        in_valid       = 1'b0;
  logic        in_ready;
  logic [9:0]  in_byte_length = '0;
  logic        out_valid;
  logic        out_ready      = 1'b0;
  logic [63:0] out_random_word;
  logic [3:0]  out_valid_bytes;
  logic        out_last_word;
  logic        cfg_we         = 1'b0;
  logic [63:0] cfg_wdata      = '0;
  logic        check_drained  = 1'b0;

  int fail_count;
  int words_pending;

  // Flow-control knobs shared between the stimulus and the result sink.
  bit allow_gaps   = 1'b1;  // both sides draw a random idle gap per transfer when set
  bit hold_results = 1'b0;  // ask the sink for one long hold-off

  xoshiro_random_byte_source #(
    .MAX_REQUEST_BYTES(MAX_BYTES)
  ) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_byte_length  (in_byte_length),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_random_word (out_random_word),
    .out_valid_bytes (out_valid_bytes),
    .out_last_word   (out_last_word),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata)
  );

  xrbs_word_checker #(
    .MAX_REQUEST_BYTES(MAX_BYTES)
  ) u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_byte_length  (in_byte_length),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_random_word (out_random_word),
    .out_valid_bytes (out_valid_bytes),
    .out_last_word   (out_last_word),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .check_drained   (check_drained),
    .fail_count      (fail_count),
    .words_pending   (words_pending)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Hard limit on the whole run; a correct run ends far sooner.
  initial begin
    #12_000_000;
    $display("tb_top: FAIL");
    $finish;
  end

  // Offer one request: idle for a drawn gap, then hold valid and the length until the
  // transfer. With no gap, valid simply stays high from the previous request.
  task automatic send_request(input int length);
    int gap;
    gap = allow_gaps ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_byte_length <= 10'(length);
    do @(posedge clk); while (!in_ready);
  endtask

  // Drop valid, wait until every predicted word has been taken, then let the block settle
  // in case the last request was empty.
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (words_pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Seed writes only ever happen with the block idle.
  task automatic write_seed(input logic [63:0] value);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Mostly short requests, some long ones, a few oversized and a few empty.
  function automatic int random_length();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 5)  return 0;
    if (pick < 60) return $urandom_range(1, 24);
    if (pick < 85) return $urandom_range(25, 128);
    if (pick < 95) return $urandom_range(129, MAX_BYTES);
    return $urandom_range(MAX_BYTES + 1, 1023);
  endfunction

  task automatic random_phase(input int count, input logic [63:0] seed);
    write_seed(seed);
    repeat (count) send_request(random_length());
  endtask

  initial begin : stimulus
    // Directed lengths: empty, single bytes, partial and full words, the saturation
    // boundary, oversized up to all ones, and an empty request between real ones.
    int lens_zero_seed [] = '{0, 1, 7, 8, 9, 16, 1023, 0, 513, 3};
    int lens_ones_seed [] = '{512, 1, 0, 64, 5};
    int lens_mixed_seed[] = '{15, 24, 2, 1000, 0};
    int lens_reseed    [] = '{512, 1};

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Start straight from the reset seed of zero, with no write.
    foreach (lens_zero_seed[i]) send_request(lens_zero_seed[i]);
    write_seed('1);
    foreach (lens_ones_seed[i]) send_request(lens_ones_seed[i]);
    write_seed(64'h0123_4567_89AB_CDEF);
    foreach (lens_mixed_seed[i]) send_request(lens_mixed_seed[i]);
    // Rewrite the all-ones seed: the sequence must restart from the same point.
    write_seed('1);
    foreach (lens_reseed[i]) send_request(lens_reseed[i]);

    // Random part, one fresh seed per phase.
    random_phase(80, {$urandom, $urandom});

    // A stretch with no idling on either side.
    allow_gaps = 1'b0;
    random_phase(70, {$urandom, $urandom});
    allow_gaps = 1'b1;

    // Back-pressure: the sink holds off for a long stretch while requests keep coming,
    // so the output fills and the request channel stalls.
    hold_results = 1'b1;
    random_phase(70, {$urandom, $urandom});

    random_phase(100, {$urandom, $urandom});
    random_phase(100, {$urandom, $urandom});

    // Drain, then ask the checker to flag anything still outstanding.
    wait_idle();
    check_drained <= 1'b1;
    @(posedge clk);
    check_drained <= 1'b0;
    @(posedge clk);

    if (fail_count == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

  // Result sink: draw a stall per word, then take the next transfer. A pending long
  // hold-off request replaces the drawn stall once.
  initial begin : result_sink
    int stall;
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_results) begin
        stall        = LONG_HOLD_CYCLES;
        hold_results = 1'b0;
      end else begin
        stall = allow_gaps ? $urandom_range(0, 4) : 0;
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

endmodule
